>>> design/kts_pkg.sv
`timescale 1ns / 1ps

package kts_pkg;

  // Width of node numbers and of the node_count register on the ports.
  localparam int unsigned NODE_W = 7;

  // Value of node_count after reset.
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

endpackage

>>> design/topological_sort_kahn_core.sv
// Edge beat: IDLE then ADD, plus LINK when the source already has out-edges (list tail link).
// Run beat: SEED reads every in-degree, then POP, POPW and HEAD per popped node,
// plus EDGE and DEC per walked edge; POP settles the result, then ERD and EOUT per
// emitted order beat or CYC for a cyclic beat, plus output stalls.
// Every step is bounded by the single read port of each state memory.
// Reset (rst_ni low, async) empties the graph and sets node_count to 64.
`timescale 1ns / 1ps

module topological_sort_kahn_core import kts_pkg::*; #(
  parameter int unsigned MAX_NODES = 64,
  parameter int unsigned MAX_EDGES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [NODE_W-1:0] src_node_i,
  input  logic [NODE_W-1:0] dst_node_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [NODE_W-1:0] node_o,
  output logic              last_o,
  output logic              cyclic_o,
  output logic              edges_dropped_o
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);
  localparam logic [EW-1:0] NULL_E = EW'(MAX_EDGES);
  localparam logic [CW-1:0] QCAP   = CW'(MAX_NODES);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_LINK, S_SEED, S_POP, S_POPW, S_HEAD,
    S_EDGE, S_DEC, S_ERD, S_EOUT, S_CYC
  } state_e;

  state_e state_q, state_d;

  logic [NODE_W-1:0] node_count_q, n_eff;
  logic [EW-1:0] edges_q, edges_d;
  logic          dropped_q, dropped_d, drop_run_q, drop_run_d;
  logic [NW-1:0] s_q, s_d, d_q, d_d, v_q, v_d, em_q, em_d, seed_idx_q, seed_idx_d;
  logic [IW-1:0] enew_q, enew_d;
  logic [EW-1:0] ofinal_q, ofinal_d, e_q, e_d;
  logic [CW-1:0] seed_cnt_q, seed_cnt_d, rp_q, rp_d, wp_q, wp_d;
  logic          seed_pend_q, seed_pend_d;
  logic          clear_graph;

  // valid bits stand in for the reset value of the per-node tables
  logic [MAX_NODES-1:0] head_vld_q, indeg_vld_q;
  logic                 head_rv_q, indeg_rv_q;

  logic              out_valid_q, out_valid_d, last_q, last_d, cyc_q, cyc_d;
  logic              odrop_q, odrop_d;
  logic [NODE_W-1:0] onode_q, onode_d;

  // memory ports
  logic          head_we, head_re, indeg_we, indeg_re, tgt_we, link_we, tl_re, q_we, q_re;
  logic [NW-1:0] head_waddr, head_raddr, indeg_waddr, indeg_raddr, q_waddr, q_raddr;
  logic [IW-1:0] tgt_waddr, link_waddr, tl_raddr;
  logic [2*EW-1:0] head_wdata, head_rdata;
  logic [EW-1:0] indeg_wdata, indeg_rdata, link_wdata, link_rdata;
  logic [NW-1:0] tgt_wdata, tgt_rdata, q_wdata, q_rdata;

  logic [EW-1:0] ofirst, ofinal, ideg;
  logic [NODE_W-1:0] src_m1, dst_m1;
  logic          edge_bad, can_load, in_acc;

  always_comb begin
    if (node_count_q == '0) begin
      n_eff = NODE_W'(1);
    end else if (node_count_q > NODE_W'(MAX_NODES)) begin
      n_eff = NODE_W'(MAX_NODES);
    end else begin
      n_eff = node_count_q;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign src_m1     = src_node_i - NODE_W'(1);
  assign dst_m1     = dst_node_i - NODE_W'(1);
  assign edge_bad   = (src_node_i == '0) || (src_node_i > n_eff) ||
                      (dst_node_i == '0) || (dst_node_i > n_eff) || (edges_q == NULL_E);
  assign ofirst     = head_rv_q ? head_rdata[2*EW-1:EW] : NULL_E;
  assign ofinal     = head_rv_q ? head_rdata[EW-1:0] : NULL_E;
  assign ideg       = indeg_rv_q ? indeg_rdata : '0;
  // output register frees up when empty or taken this cycle
  assign can_load   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    edges_d = edges_q;
    dropped_d = dropped_q;
    drop_run_d = drop_run_q;
    s_d = s_q;  d_d = d_q;  v_d = v_q;  em_d = em_q;
    seed_idx_d = seed_idx_q;
    enew_d = enew_q;  ofinal_d = ofinal_q;  e_d = e_q;
    seed_cnt_d = seed_cnt_q;  rp_d = rp_q;  wp_d = wp_q;
    seed_pend_d = 1'b0;
    clear_graph = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    onode_d = onode_q;  last_d = last_q;  cyc_d = cyc_q;  odrop_d = odrop_q;

    head_we = 1'b0;  head_waddr = s_q;  head_wdata = '0;
    head_re = 1'b0;  head_raddr = src_m1[NW-1:0];
    indeg_we = 1'b0; indeg_waddr = d_q; indeg_wdata = '0;
    indeg_re = 1'b0; indeg_raddr = dst_m1[NW-1:0];
    tgt_we = 1'b0;   tgt_waddr = enew_q; tgt_wdata = d_q;
    link_we = 1'b0;  link_waddr = enew_q; link_wdata = NULL_E;
    tl_re = 1'b0;    tl_raddr = e_q[IW-1:0];
    q_we = 1'b0;     q_waddr = wp_q[NW-1:0]; q_wdata = seed_idx_q;
    q_re = 1'b0;     q_raddr = rp_q[NW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (action_i) begin
            drop_run_d = dropped_q;
            seed_cnt_d = '0;
            rp_d = '0;
            wp_d = '0;
            state_d = S_SEED;
          end else if (edge_bad) begin
            dropped_d = 1'b1;
          end else begin
            head_re = 1'b1;
            indeg_re = 1'b1;
            s_d = src_m1[NW-1:0];
            d_d = dst_m1[NW-1:0];
            enew_d = edges_q[IW-1:0];
            state_d = S_ADD;
          end
        end
      end
      S_ADD: begin
        tgt_we = 1'b1;
        link_we = 1'b1;
        head_we = 1'b1;
        head_wdata = {(ofirst == NULL_E) ? EW'(enew_q) : ofirst, EW'(enew_q)};
        indeg_we = 1'b1;
        indeg_wdata = ideg + EW'(1);
        edges_d = edges_q + EW'(1);
        if (ofirst != NULL_E) begin
          ofinal_d = ofinal;
          state_d = S_LINK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LINK: begin
        // append to the tail of the source's list
        link_we = 1'b1;
        link_waddr = ofinal_q[IW-1:0];
        link_wdata = EW'(enew_q);
        state_d = S_IDLE;
      end
      S_SEED: begin
        if (NODE_W'(seed_cnt_q) < n_eff) begin
          indeg_re = 1'b1;
          indeg_raddr = seed_cnt_q[NW-1:0];
          seed_idx_d = seed_cnt_q[NW-1:0];
          seed_pend_d = 1'b1;
          seed_cnt_d = seed_cnt_q + CW'(1);
        end
        if (seed_pend_q && ideg == '0 && wp_q < QCAP) begin
          q_we = 1'b1;
          q_wdata = seed_idx_q;
          wp_d = wp_q + CW'(1);
        end
        if (NODE_W'(seed_cnt_q) == n_eff && !seed_pend_q) begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        if (rp_q < wp_q) begin
          q_re = 1'b1;
          rp_d = rp_q + CW'(1);
          state_d = S_POPW;
        end else if (NODE_W'(wp_q) == n_eff) begin
          em_d = '0;
          state_d = S_ERD;
        end else begin
          state_d = S_CYC;
        end
      end
      S_POPW: begin
        head_re = 1'b1;
        head_raddr = q_rdata;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        if (ofirst == NULL_E) begin
          state_d = S_POP;
        end else begin
          tl_re = 1'b1;
          tl_raddr = ofirst[IW-1:0];
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        if (NODE_W'(tgt_rdata) < n_eff) begin
          indeg_re = 1'b1;
          indeg_raddr = tgt_rdata;
          v_d = tgt_rdata;
          e_d = link_rdata;
          state_d = S_DEC;
        end else if (link_rdata == NULL_E) begin
          state_d = S_POP;
        end else begin
          // successor above node_count: skip it
          tl_re = 1'b1;
          tl_raddr = link_rdata[IW-1:0];
        end
      end
      S_DEC: begin
        if (ideg != '0) begin
          indeg_we = 1'b1;
          indeg_waddr = v_q;
          indeg_wdata = ideg - EW'(1);
          if (ideg == EW'(1) && wp_q < QCAP) begin
            q_we = 1'b1;
            q_wdata = v_q;
            wp_d = wp_q + CW'(1);
          end
        end
        if (e_q == NULL_E) begin
          state_d = S_POP;
        end else begin
          tl_re = 1'b1;
          state_d = S_EDGE;
        end
      end
      S_ERD: begin
        q_re = 1'b1;
        q_raddr = em_q;
        state_d = S_EOUT;
      end
      S_EOUT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          onode_d = NODE_W'(q_rdata) + NODE_W'(1);
          cyc_d = 1'b0;
          odrop_d = drop_run_q;
          last_d = ((CW'(em_q) + CW'(1)) == wp_q);
          if ((CW'(em_q) + CW'(1)) == wp_q) begin
            clear_graph = 1'b1;
            state_d = S_IDLE;
          end else begin
            em_d = em_q + NW'(1);
            state_d = S_ERD;
          end
        end
      end
      S_CYC: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          onode_d = '0;
          cyc_d = 1'b1;
          last_d = 1'b1;
          odrop_d = drop_run_q;
          clear_graph = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (clear_graph) begin
      edges_d = '0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      node_count_q <= NODE_COUNT_RST;
      edges_q <= '0;
      dropped_q <= 1'b0;
      drop_run_q <= 1'b0;
      seed_cnt_q <= '0;
      seed_pend_q <= 1'b0;
      rp_q <= '0;
      wp_q <= '0;
      head_vld_q <= '0;
      indeg_vld_q <= '0;
      head_rv_q <= 1'b0;
      indeg_rv_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      edges_q <= edges_d;
      dropped_q <= dropped_d;
      drop_run_q <= drop_run_d;
      seed_cnt_q <= seed_cnt_d;
      seed_pend_q <= seed_pend_d;
      rp_q <= rp_d;
      wp_q <= wp_d;
      if (head_re) begin
        head_rv_q <= head_vld_q[head_raddr];
      end
      if (indeg_re) begin
        indeg_rv_q <= indeg_vld_q[indeg_raddr];
      end
      if (clear_graph) begin
        head_vld_q <= '0;
        indeg_vld_q <= '0;
      end else begin
        if (head_we) begin
          head_vld_q[head_waddr] <= 1'b1;
        end
        if (indeg_we) begin
          indeg_vld_q[indeg_waddr] <= 1'b1;
        end
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    d_q <= d_d;
    v_q <= v_d;
    em_q <= em_d;
    seed_idx_q <= seed_idx_d;
    enew_q <= enew_d;
    ofinal_q <= ofinal_d;
    e_q <= e_d;
    onode_q <= onode_d;
    last_q <= last_d;
    cyc_q <= cyc_d;
    odrop_q <= odrop_d;
  end

  // list head and tail per node
  kts_ram #(.DEPTH(MAX_NODES), .WIDTH(2 * EW), .AW(NW)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(head_re), .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  // in-degree per node
  kts_ram #(.DEPTH(MAX_NODES), .WIDTH(EW), .AW(NW)) u_indeg (
    .clk_i, .we_i(indeg_we), .waddr_i(indeg_waddr), .wdata_i(indeg_wdata),
    .re_i(indeg_re), .raddr_i(indeg_raddr), .rdata_o(indeg_rdata)
  );

  // edge target node
  kts_ram #(.DEPTH(MAX_EDGES), .WIDTH(NW), .AW(IW)) u_tgt (
    .clk_i, .we_i(tgt_we), .waddr_i(tgt_waddr), .wdata_i(tgt_wdata),
    .re_i(tl_re), .raddr_i(tl_raddr), .rdata_o(tgt_rdata)
  );

  // next edge of the same source
  kts_ram #(.DEPTH(MAX_EDGES), .WIDTH(EW), .AW(IW)) u_link (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .re_i(tl_re), .raddr_i(tl_raddr), .rdata_o(link_rdata)
  );

  // ready queue, also holds the final order
  kts_ram #(.DEPTH(MAX_NODES), .WIDTH(NW), .AW(NW)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .re_i(q_re), .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign node_o          = onode_q;
  assign last_o          = last_q;
  assign cyclic_o        = cyc_q;
  assign edges_dropped_o = odrop_q;

endmodule

>>> design/kts_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module kts_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/kts_checker.sv
`timescale 1ns / 1ps

module kts_checker import kts_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              action_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [NODE_W-1:0] node_o,
  input logic              last_o,
  input logic              cyclic_o
);

  a_cyc_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cyclic_o |-> node_o == '0 && last_o)
    else $error("cyclic beat malformed");

  a_node_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cyclic_o |-> node_o != '0)
    else $error("order beat with node zero");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i |=> in_stall_o)
    else $error("run beat did not occupy the block");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken while a run still emits");

endmodule

bind topological_sort_kahn_core kts_checker u_kts_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i,
  .out_valid_o, .out_stall_i, .node_o, .last_o, .cyclic_o
);
